// ===== rtl/core/ipa_pkg.sv =====
// shared constants and controller/datapath handshake types for the interval assigner
package ipa_pkg;

	// time resolution of incoming timestamps and of the top-level partition grid
	localparam int TIME_BITS = 32;
	localparam int TOP_BITS = 16;

	// field widths
	localparam int TS_W = 32;
	localparam int ID_W = 32;
	localparam int LVL_W = 5;
	localparam int BKT_W = 16;

	// right shift that turns a timestamp into a level 0 bucket
	localparam int SHIFT_RAW = (TIME_BITS > TOP_BITS) ? (TIME_BITS - TOP_BITS) : 0;
	localparam int SHIFT = (SHIFT_RAW > 63) ? 63 : SHIFT_RAW;

	// width of a shifted bucket index (at least one bit)
	localparam int BW = (SHIFT >= TS_W) ? 1 : (TS_W - SHIFT);

	// deepest hierarchy supported
	localparam logic [LVL_W-1:0] MAX_LEVELS = LVL_W'(17);

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic step_lo;
		logic step_hi;
		logic flush;
	} ipa_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic walk_cont;
		logic out_free;
		logic pend_valid;
	} ipa_sts_t;

endpackage

// ===== rtl/core/ipa_ctrl.sv =====
// controller state machine: sequences the low and high phases of each level
module ipa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ipa_pkg::ipa_sts_t sts,
	output ipa_pkg::ipa_cmd_t cmd
);
	import ipa_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_LO    = 4'b0010,
		ST_HI    = 4'b0100,
		ST_FLUSH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state and command decode
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_LO;
				end
			end
			ST_LO: begin
				if (!sts.walk_cont) begin
					state_d = ST_FLUSH;
				end else if (sts.out_free) begin
					cmd.step_lo = 1'b1;
					state_d = ST_HI;
				end
			end
			ST_HI: begin
				if (sts.out_free) begin
					cmd.step_hi = 1'b1;
					state_d = ST_LO;
				end
			end
			ST_FLUSH: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/ipa_dpath.sv =====
// datapath: bucket walk registers, one-deep pending result and output register
module ipa_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ipa_pkg::LVL_W-1:0]    cfg_wdata,
	input  logic [ipa_pkg::TS_W-1:0]     interval_start,
	input  logic [ipa_pkg::TS_W-1:0]     interval_end,
	input  logic [ipa_pkg::ID_W-1:0]     record_id,
	input  ipa_pkg::ipa_cmd_t            cmd,
	output ipa_pkg::ipa_sts_t            sts,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ipa_pkg::LVL_W-1:0]    level,
	output logic [ipa_pkg::BKT_W-1:0]    bucket,
	output logic                         is_original,
	output logic [ipa_pkg::ID_W-1:0]     id_out,
	output logic                         last
);
	import ipa_pkg::*;

	logic [LVL_W-1:0] level_count_q;
	logic [LVL_W-1:0] levels_q;
	logic [LVL_W-1:0] lvl_q;
	logic [BW:0]      a_q;
	logic [BW-1:0]    b_q;
	logic [ID_W-1:0]  id_q;
	logic             found_q;
	logic             below_q;

	logic             pend_valid_q;
	logic [LVL_W-1:0] pend_lvl_q;
	logic [BKT_W-1:0] pend_bkt_q;
	logic             pend_orig_q;

	logic             out_valid_q;
	logic [LVL_W-1:0] out_lvl_q;
	logic [BKT_W-1:0] out_bkt_q;
	logic             out_orig_q;
	logic [ID_W-1:0]  out_id_q;
	logic             out_last_q;

	logic             emit_lo;
	logic             emit_hi;
	logic             emit;
	logic             b_zero;
	logic [BW-1:0]    b_dec;
	logic [BW-1:0]    b_next;
	logic [BW:0]      a_inc;
	logic             lt_hi;
	logic [BKT_W-1:0] new_bkt;
	logic             new_orig;
	logic             push_mid;
	logic             push_last;
	logic             push;
	logic             out_free;

	// emission decisions for the current phase
	assign emit_lo = cmd.step_lo && a_q[0];
	assign emit_hi = cmd.step_hi && !b_q[0];
	assign emit = emit_lo || emit_hi;
	assign b_zero = (b_q == '0);
	assign b_dec = b_q - BW'(1);
	assign lt_hi = b_zero || ({1'b0, b_dec} < a_q);
	assign a_inc = a_q + (BW+1)'(1);
	assign b_next = (!b_q[0] && !b_zero) ? b_dec : b_q;
	assign new_bkt = emit_lo ? BKT_W'(a_q) : BKT_W'(b_q);
	assign new_orig = emit_lo ? !found_q : (!found_q && lt_hi);

	// pending result moves out when a newer one arrives or the walk ends
	assign push_mid = emit && pend_valid_q;
	assign push_last = cmd.flush && pend_valid_q;
	assign push = push_mid || push_last;
	assign out_free = !out_valid_q || out_ready;

	// status back to the controller
	always_comb begin
		sts.walk_cont = (lvl_q < levels_q) && (a_q <= {1'b0, b_q}) && !below_q;
		sts.out_free = out_free;
		sts.pend_valid = pend_valid_q;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_count_q <= MAX_LEVELS;
			found_q <= 1'b0;
			below_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				level_count_q <= cfg_wdata;
			end
			if (cmd.load) begin
				found_q <= 1'b0;
				below_q <= 1'b0;
			end else begin
				if (emit_lo) begin
					found_q <= 1'b1;
				end
				if (emit_hi && b_zero) begin
					below_q <= 1'b1;
				end
			end
			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush || cmd.load) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// walk registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q <= {1'b0, BW'(interval_start >> SHIFT)};
			b_q <= BW'(interval_end >> SHIFT);
			id_q <= record_id;
			lvl_q <= '0;
			levels_q <= (level_count_q > MAX_LEVELS) ? MAX_LEVELS : level_count_q;
		end else if (cmd.step_lo) begin
			if (a_q[0]) begin
				a_q <= a_inc;
			end
		end else if (cmd.step_hi) begin
			a_q <= a_q >> 1;
			b_q <= b_next >> 1;
			lvl_q <= lvl_q + LVL_W'(1);
		end
	end

	// pending result and output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pend_lvl_q <= lvl_q;
			pend_bkt_q <= new_bkt;
			pend_orig_q <= new_orig;
		end
		if (push) begin
			out_lvl_q <= pend_lvl_q;
			out_bkt_q <= pend_bkt_q;
			out_orig_q <= pend_orig_q;
			out_id_q <= id_q;
			out_last_q <= push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign level = out_lvl_q;
	assign bucket = out_bkt_q;
	assign is_original = out_orig_q;
	assign id_out = out_id_q;
	assign last = out_last_q;

endmodule

// ===== rtl/core/interval_partition_assign_top.sv =====
// top level of the hierarchical interval partition assigner
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   in      | input     | in_valid / in_ready  | interval_start, interval_end, record_id
//   out     | output    | out_valid / out_ready| level, bucket, is_original, id_out, last
//   cfg     | input     | cfg_we (no wait)     | cfg_wdata (level_count)
//
// A record is loaded, then walked level by level in a low phase and a high phase; one more
// low phase sees the walk end and a flush state closes it, with up to seventeen levels walked.
// Each phase emits at most one assignment; the last one is held back one emission
// so that it can be flagged. Output back-pressure stalls the walk phase by phase.
// Reset clears the controller, valid flags and sets level_count to 17.
// A new record is taken once the previous one has handed its final assignment to
// the output register, even while that register still waits for a transfer.
module interval_partition_assign_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ipa_pkg::LVL_W-1:0] cfg_wdata,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [ipa_pkg::TS_W-1:0]  interval_start,
	input  logic [ipa_pkg::TS_W-1:0]  interval_end,
	input  logic [ipa_pkg::ID_W-1:0]  record_id,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [ipa_pkg::LVL_W-1:0] level,
	output logic [ipa_pkg::BKT_W-1:0] bucket,
	output logic                      is_original,
	output logic [ipa_pkg::ID_W-1:0]  id_out,
	output logic                      last
);
	import ipa_pkg::*;

	ipa_cmd_t cmd;
	ipa_sts_t sts;

	// phase sequencer
	ipa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// bucket walk and result registers
	ipa_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.interval_start (interval_start),
		.interval_end   (interval_end),
		.record_id      (record_id),
		.cmd            (cmd),
		.sts            (sts),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.level          (level),
		.bucket         (bucket),
		.is_original    (is_original),
		.id_out         (id_out),
		.last           (last)
	);

endmodule

// ===== rtl/core/ipa_checker.sv =====
// port-level checks for the interval partition assigner, bound to the top level
module ipa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [ipa_pkg::LVL_W-1:0] level,
	input logic [ipa_pkg::BKT_W-1:0] bucket,
	input logic                      is_original,
	input logic [ipa_pkg::ID_W-1:0]  id_out,
	input logic                      last
);
	import ipa_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(level) && $stable(bucket)
			&& $stable(is_original) && $stable(id_out) && $stable(last))
		else $error("output changed while stalled");

	// levels never go beyond the deepest one
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> level < MAX_LEVELS)
		else $error("level out of range");

	// one record at a time: busy right after a transfer in
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while walking");

	// a new record only starts once the previous record has closed
	a_closed_before_next: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && out_valid |-> last)
		else $error("record started with an unfinished one waiting");

endmodule

bind interval_partition_assign_top ipa_checker u_ipa_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.level       (level),
	.bucket      (bucket),
	.is_original (is_original),
	.id_out      (id_out),
	.last        (last)
);

// ===== tb/ipa_checker.sv =====
// checker for the interval partition assigner: predicts assignments and compares transfers
module ipa_scoreboard
	import ipa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LVL_W-1:0] cfg_wdata,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [TS_W-1:0]  interval_start,
	input  logic [TS_W-1:0]  interval_end,
	input  logic [ID_W-1:0]  record_id,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [LVL_W-1:0] level,
	input  logic [BKT_W-1:0] bucket,
	input  logic             is_original,
	input  logic [ID_W-1:0]  id_out,
	input  logic             last,
	output int               failures,
	output int               outstanding
);

	// keep the log readable when the block is badly broken
	localparam int PRINT_CAP = 100;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic [BKT_W-1:0] bucket;
		logic             is_original;
		logic [ID_W-1:0]  id_out;
		logic             last;
	} assignment_t;

	assignment_t      expected_assignments[$];
	logic [LVL_W-1:0] level_count;

	initial begin
		failures = 0;
		outstanding = 0;
		level_count = MAX_LEVELS;
	end

	task automatic flag_mismatch(input string msg);
		if (failures < PRINT_CAP)
			$display("MISMATCH @%0t: %s", $time, msg);
		failures++;
	endtask

	// walk one record up the hierarchy and queue every partition it lands in
	function automatic void predict_assignments(input logic [TS_W-1:0] t_start,
		input logic [TS_W-1:0] t_end, input logic [ID_W-1:0] rid);
		logic [63:0]      lo;
		logic [63:0]      hi;
		logic [LVL_W-1:0] depth;
		int               lvl;
		int               first_new;
		int               tail;
		bit               found;
		bit               hit_floor;
		assignment_t      r;
		lo = 64'(t_start) >> SHIFT;
		hi = 64'(t_end) >> SHIFT;
		depth = (level_count > MAX_LEVELS) ? MAX_LEVELS : level_count;
		lvl = 0;
		found = 1'b0;
		hit_floor = 1'b0;
		first_new = expected_assignments.size();
		while (lvl < int'(depth) && lo <= hi && !hit_floor) begin
			// odd low end: its bucket is covered here
			if (lo[0]) begin
				r.level = LVL_W'(lvl);
				r.bucket = lo[BKT_W-1:0];
				r.is_original = !found;
				r.id_out = rid;
				r.last = 1'b0;
				expected_assignments.insert(expected_assignments.size(), r);
				found = 1'b1;
				lo = lo + 1;
			end
			// even high end: its bucket is covered here, bucket zero ends the walk
			if (!hi[0]) begin
				r.level = LVL_W'(lvl);
				r.bucket = hi[BKT_W-1:0];
				r.id_out = rid;
				r.last = 1'b0;
				if (hi == 0) begin
					hit_floor = 1'b1;
					r.is_original = !found;
				end else begin
					r.is_original = !found && ((hi - 1) < lo);
					hi = hi - 1;
				end
				expected_assignments.insert(expected_assignments.size(), r);
			end
			lo = lo >> 1;
			hi = hi >> 1;
			lvl++;
		end
		// flag the final assignment of the record
		tail = expected_assignments.size() - 1;
		if (tail >= first_new) begin
			r = expected_assignments[tail];
			r.last = 1'b1;
			expected_assignments[tail] = r;
		end
	endfunction

	// sample both channels and the register port at each edge
	always @(posedge clk or negedge arst_n) begin
		assignment_t want;
		if (!arst_n) begin
			level_count = MAX_LEVELS;
			expected_assignments.delete();
		end else begin
			if (in_valid && in_ready)
				predict_assignments(interval_start, interval_end, record_id);
			if (cfg_we)
				level_count = cfg_wdata;
			if (out_valid && out_ready) begin
				if (expected_assignments.size() == 0) begin
					flag_mismatch($sformatf("unexpected transfer level %0d bucket %h id %h",
						level, bucket, id_out));
				end else begin
					want = expected_assignments.pop_front();
					if (level !== want.level)
						flag_mismatch($sformatf("level %0d, want %0d (id %h bucket %h)",
							level, want.level, want.id_out, want.bucket));
					if (bucket !== want.bucket)
						flag_mismatch($sformatf("bucket %h, want %h (id %h level %0d)",
							bucket, want.bucket, want.id_out, want.level));
					if (is_original !== want.is_original)
						flag_mismatch($sformatf("is_original %b, want %b (id %h level %0d)",
							is_original, want.is_original, want.id_out, want.level));
					if (id_out !== want.id_out)
						flag_mismatch($sformatf("id_out %h, want %h (level %0d bucket %h)",
							id_out, want.id_out, want.level, want.bucket));
					if (last !== want.last)
						flag_mismatch($sformatf("last %b, want %b (id %h level %0d)",
							last, want.last, want.id_out, want.level));
				end
			end
		end
		outstanding = expected_assignments.size();
	end

endmodule

// ===== tb/tb_interval_partition_assign_top.sv =====
// stimulus and verdict for the interval partition assigner
module tb_interval_partition_assign_top;
	import ipa_pkg::*;

	localparam int PERIOD = 12;
	localparam int RESET_CYCLES = 10;
	// margin after the scoreboard empties, to cover a record still in flight
	localparam int SETTLE_CYCLES = 50;
	localparam int HOLD_CYCLES = 300;
	localparam int LIMIT_CYCLES = 600000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [LVL_W-1:0] cfg_wdata = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [TS_W-1:0]  interval_start = '0;
	logic [TS_W-1:0]  interval_end = '0;
	logic [ID_W-1:0]  record_id = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [LVL_W-1:0] level;
	logic [BKT_W-1:0] bucket;
	logic             is_original;
	logic [ID_W-1:0]  id_out;
	logic             last;

	int failures;
	int outstanding;
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;

	always #(PERIOD / 2) clk = ~clk;

	interval_partition_assign_top uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.interval_start (interval_start),
		.interval_end   (interval_end),
		.record_id      (record_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.level          (level),
		.bucket         (bucket),
		.is_original    (is_original),
		.id_out         (id_out),
		.last           (last)
	);

	ipa_scoreboard u_scoreboard (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.interval_start (interval_start),
		.interval_end   (interval_end),
		.record_id      (record_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.level          (level),
		.bucket         (bucket),
		.is_original    (is_original),
		.id_out         (id_out),
		.last           (last),
		.failures       (failures),
		.outstanding    (outstanding)
	);

	// receiver: random back-pressure, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// offer one record and wait for its transfer
	task automatic offer_record(input logic [TS_W-1:0] t_start, input logic [TS_W-1:0] t_end,
		input logic [ID_W-1:0] rid);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		interval_start <= t_start;
		interval_end <= t_end;
		record_id <= rid;
		do @(posedge clk); while (!in_ready);
	endtask

	// stop offering until every predicted assignment has been transferred
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_level_count(input logic [LVL_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly ordered intervals of mixed span, with some reversed ones as noise
	task automatic random_records(input int count);
		logic [TS_W-1:0] s;
		logic [TS_W-1:0] e;
		logic [TS_W-1:0] tmp;
		for (int i = 0; i < count; i++) begin
			s = $urandom;
			e = $urandom;
			case ($urandom_range(9))
				0: ;
				1: begin
					e = s + $urandom_range(32'h000F_FFFF);
					if (e < s)
						e = '1;
				end
				2: begin
					if ($urandom_range(1))
						s = '0;
					else
						e = '1;
				end
				3: e = s - $urandom_range(32'h0002_FFFF);
				default: begin
					if (s > e) begin
						tmp = s;
						s = e;
						e = tmp;
					end
				end
			endcase
			offer_record(s, e, $urandom);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles lightly, receiver heavily
		snd_idle_pct = 19;
		rcv_idle_pct = 46;

		// directed records with the reset level count
		offer_record(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		offer_record(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		offer_record(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		offer_record(32'h0001_0000, 32'h0001_FFFF, 32'h5A5A_5A5A);
		offer_record(32'h0002_0000, 32'h0002_0000, 32'h0000_0001);
		offer_record(32'h0005_0000, 32'h0004_FFFF, 32'h0000_0002);
		offer_record(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0003);
		offer_record(32'h0003_FFFF, 32'h0003_0000, 32'h0000_0004);
		offer_record(32'h0001_0000, 32'h0002_0000, 32'h0000_0005);
		offer_record(32'h0003_0000, 32'h0006_0000, 32'h0000_0006);
		offer_record(32'h0000_0000, 32'h0001_0000, 32'h0000_0007);
		offer_record(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
		offer_record(32'h0001_0000, 32'hFFFE_FFFF, 32'h7FFF_FFFF);
		offer_record(32'h7FFF_0000, 32'h8000_0000, 32'h0000_0008);
		offer_record(32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0009);
		offer_record(32'h0002_0000, 32'h0007_0000, 32'h0000_000A);

		// long receiver hold-off while the sender keeps pushing
		hold_req <= hold_req + 1;
		random_records(50);

		// single level only
		set_level_count(LVL_W'(1));
		random_records(30);

		// swap the idling between the two sides
		snd_idle_pct = 46;
		rcv_idle_pct = 19;

		// no levels at all: nothing comes out
		set_level_count(LVL_W'(0));
		offer_record(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000B);
		offer_record(32'h0001_0000, 32'h0001_0000, 32'h0000_000C);
		random_records(10);

		// beyond the deepest hierarchy, clamped to it
		set_level_count(LVL_W'(31));
		offer_record(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_000D);
		random_records(20);
		// sender waits for the block to empty before going on
		drain_results();
		random_records(20);

		set_level_count(LVL_W'(5));
		random_records(40);

		// no idling on either side
		snd_idle_pct = 0;
		rcv_idle_pct = 0;

		set_level_count(LVL_W'(17));
		hold_req <= hold_req + 1;
		random_records(60);

		set_level_count(LVL_W'(2));
		random_records(20);
		set_level_count(LVL_W'(12));
		random_records(20);

		drain_results();
		if (failures == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// watchdog against a hung handshake
	initial begin
		#(LIMIT_CYCLES * PERIOD);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== interval_partition_assign_top.f =====
rtl/core/ipa_pkg.sv
rtl/core/ipa_ctrl.sv
rtl/core/ipa_dpath.sv
rtl/core/interval_partition_assign_top.sv
rtl/core/ipa_checker.sv
tb/ipa_checker.sv
tb/tb_interval_partition_assign_top.sv
